// ===== rtl/cfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the CRC-checked frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam logic [7:0]  HDR1_BYTE     = 8'hA5;
  localparam logic [7:0]  HDR2_BYTE     = 8'h5A;
  localparam logic [7:0]  TRAILER_BYTE  = 8'hFF;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [7:0]  TRIGGER_RESET = 8'h21;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HDR2    = 3'd1,
    PH_LEN     = 3'd2,
    PH_CODE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_HI  = 3'd5,
    PH_CRC_LO  = 3'd6,
    PH_TRAILER = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_code;
    logic [7:0] payload_length;
    logic [7:0] first_payload;
    logic       trigger_hit;
  } frame_t;

endpackage

// ===== rtl/cfr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_if
// Valid/ready channels of the frame receiver: byte in, frame out, config.
// ----------------------------------------------------------------------------
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfr_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_code;
  logic [7:0] payload_length;
  logic [7:0] first_payload;
  logic       trigger_hit;
  modport source (output valid, output frame_code, output payload_length,
                  output first_payload, output trigger_hit, input ready);
  modport sink   (input valid, input frame_code, input payload_length,
                  input first_payload, input trigger_hit, output ready);
endinterface

interface cfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/cfr_crc_byte.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_crc_byte
// One-byte CRC-16/MODBUS update, reflected, eight bit steps.
// ----------------------------------------------------------------------------
module cfr_crc_byte
  import cfr_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// ===== rtl/cfr_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_parser
// Frame state machine: header hunt, running CRC, trailer check, result.
// ----------------------------------------------------------------------------
module cfr_parser
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] trigger_i,
  output logic       res_valid_o,
  output frame_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  code_q, code_d;
  logic [7:0]  first_q, first_d;
  logic        restart;
  logic [15:0] crc_in;
  logic [15:0] crc_next;
  logic        is_hdr1;
  logic [7:0]  left_dec;

  assign is_hdr1  = (byte_i == HDR1_BYTE);
  assign left_dec = left_q - 8'd1;
  assign restart  = (phase_q == PH_HUNT) || (phase_q == PH_HDR2 && byte_i != HDR2_BYTE)
                 || (phase_q == PH_CRC_LO) || (phase_q == PH_TRAILER);
  assign crc_in   = restart ? CRC_INIT : crc_q;

  cfr_crc_byte u_crc (
    .crc_i  (crc_in),
    .data_i (byte_i),
    .crc_o  (crc_next)
  );

  // next state
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    crc_hi_d = crc_hi_q;
    left_d   = left_q;
    len_d    = len_q;
    code_d   = code_q;
    first_d  = first_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (is_hdr1) begin
          phase_d = PH_HDR2;
          crc_d   = crc_next;
        end
      end
      PH_HDR2: begin
        if (byte_i == HDR2_BYTE) begin
          phase_d = PH_LEN;
          crc_d   = crc_next;
        end else if (is_hdr1) begin
          crc_d = crc_next;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_LEN: begin
        len_d   = byte_i;
        crc_d   = crc_next;
        phase_d = PH_CODE;
      end
      PH_CODE: begin
        code_d  = byte_i;
        crc_d   = crc_next;
        left_d  = len_q;
        phase_d = (len_q == 8'd0) ? PH_CRC_HI : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (left_q == len_q) begin
          first_d = byte_i;
        end
        crc_d  = crc_next;
        left_d = left_dec;
        if (left_dec == 8'd0) begin
          phase_d = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        crc_hi_d = byte_i;
        phase_d  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        if ({crc_hi_q, byte_i} == crc_q) begin
          phase_d = PH_TRAILER;
        end else if (is_hdr1) begin
          phase_d = PH_HDR2;
          crc_d   = crc_next;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_TRAILER: begin
        if (byte_i == TRAILER_BYTE) begin
          phase_d = PH_HUNT;
        end else if (is_hdr1) begin
          phase_d = PH_HDR2;
          crc_d   = crc_next;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // result
  always_comb begin
    res_valid_o          = (phase_q == PH_TRAILER) && (byte_i == TRAILER_BYTE);
    res_o.frame_code     = code_q;
    res_o.payload_length = len_q;
    res_o.first_payload  = first_q;
    res_o.trigger_hit    = (first_q == trigger_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      crc_q    <= CRC_INIT;
      crc_hi_q <= 8'd0;
      left_q   <= 8'd0;
      len_q    <= 8'd0;
      code_q   <= 8'd0;
      first_q  <= 8'd0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      crc_hi_q <= crc_hi_d;
      left_q   <= left_d;
      len_q    <= len_d;
      code_q   <= code_d;
      first_q  <= first_d;
    end
  end

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> left_q != 8'd0)
    else $error("payload phase with no bytes left");

  a_result_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o |=> phase_q == PH_HUNT)
    else $error("no return to hunt after a good frame");

  a_last_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_PAYLOAD && left_q == 8'd1 |=> phase_q == PH_CRC_HI)
    else $error("last payload byte did not lead to CRC");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(crc_q))
    else $error("parser state moved without a transfer");

endmodule

// ===== rtl/crc_checked_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checked_frame_receiver_unit
// Byte-stream deframer with CRC-16/MODBUS check and trigger compare.
// Output: a trailer byte taken on rx_i goes through the input register and the
//   parser; the result register then raises frame_o.valid.
// Throughput: one byte per cycle while no result waits on frame_o.ready; the byte CRC update is one combinational step.
// Reset: hunting for the first header, CRC FFFF, held fields 0, trigger 0x21.
// ----------------------------------------------------------------------------
module crc_checked_frame_receiver_unit
  import cfr_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  cfr_byte_if.sink    rx_i,
  cfr_cfg_if.sink     cfg_i,
  cfr_frame_if.source frame_o
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic [7:0] trigger_q;
  logic       out_valid_q;
  frame_t     out_q;
  logic       step;
  logic       res_valid;
  frame_t     res;

  assign step        = in_valid_q && (!out_valid_q || frame_o.ready);
  assign rx_i.ready  = !in_valid_q || step;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trigger_q <= TRIGGER_RESET;
    end else if (cfg_i.valid) begin
      trigger_q <= cfg_i.data;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  cfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .trigger_i   (trigger_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res_valid;
    end else if (frame_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign frame_o.valid          = out_valid_q;
  assign frame_o.frame_code     = out_q.frame_code;
  assign frame_o.payload_length = out_q.payload_length;
  assign frame_o.first_payload  = out_q.first_payload;
  assign frame_o.trigger_hit    = out_q.trigger_hit;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !frame_o.ready |-> !step)
    else $error("pending result overwritten");

  a_step_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> in_valid_q)
    else $error("parser advanced on an empty input register");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && frame_o.ready && !step |=> !out_valid_q)
    else $error("taken result not cleared");

endmodule
